FILE: hdl/ska_pkg.sv
`timescale 1ns / 1ps
package ska_pkg;

  // Segment table geometry.
  localparam int SEG_N = 64;
  localparam int IDX_W = $clog2(SEG_N);
  localparam int CNT_W = IDX_W + 1;

  // Pixel widths.
  localparam int DIM_W = 13;
  localparam int POS_W = 12;
  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;
  localparam logic [DIM_W-1:0] RESET_DIM = 13'd1024;

  // Configuration register indexes.
  localparam logic [1:0] REG_ATLAS_WIDTH = 2'd0;
  localparam logic [1:0] REG_ATLAS_HEIGHT = 2'd1;

  // Command codes.
  localparam logic CMD_PACK = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP_W,
    S_PREP_H,
    S_OUTER,
    S_START,
    S_SCAN,
    S_CAND,
    S_LEFT,
    S_DECIDE,
    S_MV_RD,
    S_MV_WR,
    S_WR_TOP,
    S_WR_TAIL,
    S_FIN
  } seq_state_e;

  // One skyline segment.
  typedef struct packed {
    logic [POS_W-1:0] left;
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] span;
  } seg_t;

endpackage

FILE: hdl/ska_alu.sv
`timescale 1ns / 1ps
module ska_alu (
  input  ska_pkg::alu_op_e         op_i,
  input  logic [ska_pkg::DIM_W-1:0] a_i,
  input  logic [ska_pkg::DIM_W-1:0] b_i,
  output logic [ska_pkg::DIM_W-1:0] res_o,
  output logic                      borrow_o
);
  import ska_pkg::*;

  logic [DIM_W:0] full;

  // Shared adder and subtractor; the top bit is the borrow on a subtract.
  always_comb begin
    case (op_i)
      ALU_ADD: full = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: full = {1'b0, a_i} - {1'b0, b_i};
      default: full = '0;
    endcase
  end

  assign res_o    = full[DIM_W-1:0];
  assign borrow_o = (op_i == ALU_SUB) && full[DIM_W];

endmodule

FILE: hdl/ska_seg_store.sv
`timescale 1ns / 1ps
module ska_seg_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic                       commit_i,
  input  logic [ska_pkg::DIM_W-1:0]  width_i,
  input  logic                       rd_en_i,
  input  logic [ska_pkg::IDX_W-1:0]  rd_addr_i,
  output ska_pkg::seg_t              rd_data_o,
  input  logic                       wr_en_i,
  input  logic [ska_pkg::IDX_W-1:0]  wr_addr_i,
  input  ska_pkg::seg_t              wr_data_i
);
  import ska_pkg::*;

  seg_t             mem [SEG_N];
  seg_t             rd_q;
  logic [IDX_W-1:0] rd_addr_q;
  logic             flat_q;
  logic [DIM_W-1:0] flat_span_q;

  // Segment memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q      <= mem[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
  end

  // While the table is flat, entry zero comes from registers, not the memory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flat_q      <= 1'b1;
      flat_span_q <= RESET_DIM;
    end else if (clear_i) begin
      flat_q      <= 1'b1;
      flat_span_q <= width_i;
    end else if (commit_i) begin
      flat_q      <= 1'b0;
    end
  end

  always_comb begin
    if (flat_q && (rd_addr_q == '0)) begin
      rd_data_o = '{left: '0, top: '0, span: flat_span_q};
    end else begin
      rd_data_o = rd_q;
    end
  end

endmodule

FILE: hdl/skyline_rect_allocator_top.sv
`timescale 1ns / 1ps
// Skyline rectangle allocator. Each beat on the input channel is either a
// clear, which restores one flat segment over the atlas width, or a pack
// request, which returns the bottom-left position of the box or a no-fit or
// table-full status; exactly one result beat follows every input beat. The
// block works on one request at a time and holds in_stall_o high meanwhile.
// A clear goes straight to the finish step, and a rejected size skips the
// search. A pack request first checks the size against the atlas width and
// height, then tries every segment as a start and walks forward through the
// segment memory one entry a cycle. A decide step follows, then the commit
// shifts the tail of the table with a read and a write per moved entry and
// writes 1 or 2 entries, and the finish step hands over the result once the
// output register is free. The single read port of the segment memory and
// the one shared adder pace this work. No clearing pass is needed after
// reset. The next request may be taken while a result is still waiting on
// the output.
module skyline_rect_allocator_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [ska_pkg::DIM_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       command_i,
  input  logic [ska_pkg::DIM_W-1:0]  box_width_i,
  input  logic [ska_pkg::DIM_W-1:0]  box_height_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ska_pkg::POS_W-1:0]  pos_x_o,
  output logic [ska_pkg::POS_W-1:0]  pos_y_o,
  output logic [1:0]                 status_o
);
  import ska_pkg::*;

  seq_state_e state_q, state_d;

  logic [DIM_W-1:0] aw_q, ah_q, uaw, uah;
  logic [DIM_W-1:0] w_q, w_d, h_q, h_d, lim_q, lim_d, hlim_q, hlim_d;
  logic [CNT_W-1:0] i_q, i_d, cnt_q, cnt_d, newc_q, newc_d;
  logic [IDX_W-1:0] j_q, j_d, src_q, src_d;
  logic [DIM_W-1:0] hi_q, hi_d, rem_q, rem_d, hi_n;
  logic [POS_W-1:0] cx_q, cx_d, bx_q, bx_d;
  logic [DIM_W-1:0] cy_q, cy_d, cspan_q, cspan_d, ctop_q, ctop_d;
  logic [CNT_W-1:0] cend_q, cend_d, bend_q, bend_d;
  logic [DIM_W-1:0] by_q, by_d, bleft_q, bleft_d, btop_q, btop_d;
  logic [IDX_W-1:0] bi_q, bi_d;
  logic             found_q, found_d, desc_q, desc_d;
  logic [POS_W-1:0] rx_q, rx_d, ry_q, ry_d;
  status_e          rs_q, rs_d;
  logic             ov_q, ov_d;
  logic [POS_W-1:0] ox_q, oy_q;
  status_e          os_q;
  logic             load_out;

  alu_op_e          alu_op;
  logic [DIM_W-1:0] alu_a, alu_b, alu_res;
  logic             alu_borrow;

  logic             clear, commit, rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  seg_t             rd_data, wr_data;
  logic [CNT_W:0]   newc_w, dst_w;
  logic [CNT_W-1:0] ins, dst0;

  ska_alu u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .res_o   (alu_res),
    .borrow_o(alu_borrow)
  );

  ska_seg_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (clear),
    .commit_i (commit),
    .width_i  (uaw),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  // Configuration registers, used clamped to the largest atlas size.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q <= RESET_DIM;
      ah_q <= RESET_DIM;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_ATLAS_WIDTH) begin
        aw_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_ATLAS_HEIGHT) begin
        ah_q <= cfg_data_i;
      end
    end
  end

  assign uaw = (aw_q > MAX_DIM) ? MAX_DIM : aw_q;
  assign uah = (ah_q > MAX_DIM) ? MAX_DIM : ah_q;

  // Commit geometry: new segment count and the shifted tail position.
  assign ins    = (bleft_q != '0) ? CNT_W'(2) : CNT_W'(1);
  assign newc_w = {1'b0, cnt_q} - {1'b0, bend_q} + (CNT_W+1)'(bi_q) + {1'b0, ins};
  assign dst0   = CNT_W'(bi_q) + ins;
  assign dst_w  = (CNT_W+1)'(src_q) + {1'b0, dst0} - {1'b0, bend_q};
  assign hi_n   = (rd_data.top > hi_q) ? rd_data.top : hi_q;

  // Sequencer: state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= CNT_W'(1);
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  // Working registers of the search and commit.
  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    h_q     <= h_d;
    lim_q   <= lim_d;
    hlim_q  <= hlim_d;
    i_q     <= i_d;
    j_q     <= j_d;
    hi_q    <= hi_d;
    rem_q   <= rem_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    cspan_q <= cspan_d;
    ctop_q  <= ctop_d;
    cend_q  <= cend_d;
    bx_q    <= bx_d;
    by_q    <= by_d;
    bi_q    <= bi_d;
    bend_q  <= bend_d;
    bleft_q <= bleft_d;
    btop_q  <= btop_d;
    found_q <= found_d;
    newc_q  <= newc_d;
    src_q   <= src_d;
    desc_q  <= desc_d;
    rx_q    <= rx_d;
    ry_q    <= ry_d;
    rs_q    <= rs_d;
    if (load_out) begin
      ox_q <= rx_q;
      oy_q <= ry_q;
      os_q <= rs_q;
    end
  end

  // Sequencer: next state, shared adder routing and memory control.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    w_d     = w_q;
    h_d     = h_q;
    lim_d   = lim_q;
    hlim_d  = hlim_q;
    i_d     = i_q;
    j_d     = j_q;
    hi_d    = hi_q;
    rem_d   = rem_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    cspan_d = cspan_q;
    ctop_d  = ctop_q;
    cend_d  = cend_q;
    bx_d    = bx_q;
    by_d    = by_q;
    bi_d    = bi_q;
    bend_d  = bend_q;
    bleft_d = bleft_q;
    btop_d  = btop_q;
    found_d = found_q;
    newc_d  = newc_q;
    src_d   = src_q;
    desc_d  = desc_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    rs_d    = rs_q;
    alu_op  = ALU_ADD;
    alu_a   = '0;
    alu_b   = '0;
    clear   = 1'b0;
    commit  = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    load_out = 1'b0;
    in_stall_o = 1'b1;

    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        rx_d = '0;
        ry_d = '0;
        rs_d = STAT_OK;
        if (in_valid_i) begin
          w_d = box_width_i;
          h_d = box_height_i;
          if (command_i == CMD_CLEAR) begin
            clear   = 1'b1;
            cnt_d   = CNT_W'(1);
            state_d = S_FIN;
          end else begin
            state_d = S_PREP_W;
          end
        end
      end
      // Room left of the right edge for the box start.
      S_PREP_W: begin
        alu_op = ALU_SUB;
        alu_a  = uaw;
        alu_b  = w_q;
        lim_d  = alu_res;
        if ((w_q == '0) || alu_borrow) begin
          rs_d    = STAT_NOFIT;
          state_d = S_FIN;
        end else begin
          state_d = S_PREP_H;
        end
      end
      // Highest allowed box top.
      S_PREP_H: begin
        alu_op  = ALU_SUB;
        alu_a   = uah;
        alu_b   = h_q;
        hlim_d  = alu_res;
        i_d     = '0;
        by_d    = uah;
        found_d = 1'b0;
        if ((h_q == '0) || alu_borrow) begin
          rs_d    = STAT_NOFIT;
          state_d = S_FIN;
        end else begin
          state_d = S_OUTER;
        end
      end
      S_OUTER: begin
        if (i_q == cnt_q) begin
          state_d = S_DECIDE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = i_q[IDX_W-1:0];
          state_d = S_START;
        end
      end
      // Reject starts whose box would cross the right edge.
      S_START: begin
        alu_op = ALU_SUB;
        alu_a  = lim_q;
        alu_b  = {1'b0, rd_data.left};
        hi_d   = rd_data.top;
        rem_d  = w_q;
        j_d    = i_q[IDX_W-1:0];
        cx_d   = rd_data.left;
        if (alu_borrow) begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_OUTER;
        end else begin
          state_d = S_SCAN;
        end
      end
      // Walk the covered segments, tracking the highest top.
      S_SCAN: begin
        alu_op = ALU_SUB;
        alu_a  = rem_q;
        alu_b  = rd_data.span;
        hi_d   = hi_n;
        if (alu_borrow || (alu_res == '0)) begin
          cy_d    = hi_n;
          cspan_d = rd_data.span;
          ctop_d  = rd_data.top;
          cend_d  = CNT_W'(j_q) + CNT_W'(1);
          state_d = S_CAND;
        end else begin
          rem_d = alu_res;
          if ((CNT_W'(j_q) + CNT_W'(1)) == cnt_q) begin
            i_d     = i_q + CNT_W'(1);
            state_d = S_OUTER;
          end else begin
            rd_en   = 1'b1;
            rd_addr = j_q + IDX_W'(1);
            j_d     = j_q + IDX_W'(1);
          end
        end
      end
      // Height limit, then keep only a strictly lower top.
      S_CAND: begin
        alu_op = ALU_SUB;
        alu_a  = hlim_q;
        alu_b  = cy_q;
        if (!alu_borrow && (cy_q < by_q)) begin
          state_d = S_LEFT;
        end else begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_OUTER;
        end
      end
      // Record the new best placement and its leftover tail.
      S_LEFT: begin
        alu_op  = ALU_SUB;
        alu_a   = cspan_q;
        alu_b   = rem_q;
        bleft_d = alu_res;
        bx_d    = cx_q;
        by_d    = cy_q;
        bi_d    = i_q[IDX_W-1:0];
        bend_d  = cend_q;
        btop_d  = ctop_q;
        found_d = 1'b1;
        i_d     = i_q + CNT_W'(1);
        state_d = S_OUTER;
      end
      S_DECIDE: begin
        newc_d = newc_w[CNT_W-1:0];
        if (!found_q) begin
          rs_d    = STAT_NOFIT;
          state_d = S_FIN;
        end else if (newc_w > (CNT_W+1)'(SEG_N)) begin
          rs_d    = STAT_FULL;
          state_d = S_FIN;
        end else if ((bend_q == cnt_q) || (dst0 == bend_q)) begin
          state_d = S_WR_TOP;
        end else if (dst0 > bend_q) begin
          desc_d  = 1'b1;
          src_d   = IDX_W'(cnt_q - CNT_W'(1));
          state_d = S_MV_RD;
        end else begin
          desc_d  = 1'b0;
          src_d   = bend_q[IDX_W-1:0];
          state_d = S_MV_RD;
        end
      end
      S_MV_RD: begin
        rd_en   = 1'b1;
        rd_addr = src_q;
        state_d = S_MV_WR;
      end
      // Move one tail entry to its new slot.
      S_MV_WR: begin
        wr_en   = 1'b1;
        wr_addr = dst_w[IDX_W-1:0];
        wr_data = rd_data;
        state_d = S_MV_RD;
        if (desc_q) begin
          if (CNT_W'(src_q) == bend_q) begin
            state_d = S_WR_TOP;
          end else begin
            src_d = src_q - IDX_W'(1);
          end
        end else begin
          if ((CNT_W'(src_q) + CNT_W'(1)) == cnt_q) begin
            state_d = S_WR_TOP;
          end else begin
            src_d = src_q + IDX_W'(1);
          end
        end
      end
      // Raised segment of the box width.
      S_WR_TOP: begin
        alu_op  = ALU_ADD;
        alu_a   = by_q;
        alu_b   = h_q;
        wr_en   = 1'b1;
        wr_addr = bi_q;
        wr_data = '{left: bx_q, top: alu_res, span: w_q};
        rx_d    = bx_q;
        ry_d    = by_q[POS_W-1:0];
        rs_d    = STAT_OK;
        if (bleft_q != '0) begin
          state_d = S_WR_TAIL;
        end else begin
          commit  = 1'b1;
          cnt_d   = newc_q;
          state_d = S_FIN;
        end
      end
      // Leftover tail at the old height of the last covered segment.
      S_WR_TAIL: begin
        alu_op  = ALU_ADD;
        alu_a   = {1'b0, bx_q};
        alu_b   = w_q;
        wr_en   = 1'b1;
        wr_addr = bi_q + IDX_W'(1);
        wr_data = '{left: alu_res[POS_W-1:0], top: btop_q, span: bleft_q};
        commit  = 1'b1;
        cnt_d   = newc_q;
        state_d = S_FIN;
      end
      // Hand the result to the output register once it is free.
      S_FIN: begin
        if (!ov_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register valid.
  always_comb begin
    ov_d = ov_q;
    if (load_out) begin
      ov_d = 1'b1;
    end else if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  assign out_valid_o = ov_q;
  assign pos_x_o     = ox_q;
  assign pos_y_o     = oy_q;
  assign status_o    = os_q;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= CNT_W'(SEG_N)))
    else $error("segment count out of range");

  a_load_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q == S_FIN))
    else $error("result loaded outside the finish step");

  a_fail_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && (os_q != STAT_OK)) |-> ((ox_q == '0) && (oy_q == '0)))
    else $error("rejected beat carries a position");

  a_commit_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> ((state_q == S_WR_TOP) || (state_q == S_WR_TAIL)))
    else $error("table committed outside a write step");
`endif

endmodule

FILE: tb/sv/skyline_rect_allocator_top_test.sv
`timescale 1ns / 1ps
module skyline_rect_allocator_top_test;
  import ska_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  // Expected placements for every accepted request, worked out on a private
  // copy of the skyline.
  class skyline_scoreboard;
    typedef struct {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      status_e          st;
    } place_t;

    logic [POS_W-1:0] seg_left[SEG_N];
    logic [DIM_W-1:0] seg_top[SEG_N];
    logic [DIM_W-1:0] seg_span[SEG_N];
    int               seg_count;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    place_t           placement_q[$];
    int               errors;

    function new();
      width_reg = RESET_DIM;
      height_reg = RESET_DIM;
      errors = 0;
      flatten();
    endfunction

    function int clip(logic [DIM_W-1:0] v);
      return (v > MAX_DIM) ? int'(MAX_DIM) : int'(v);
    endfunction

    function void flatten();
      seg_count = 1;
      seg_left[0] = '0;
      seg_top[0] = '0;
      seg_span[0] = DIM_W'(clip(width_reg));
    endfunction

    function void set_reg(logic [1:0] idx, logic [DIM_W-1:0] val);
      if (idx == REG_ATLAS_WIDTH) width_reg = val;
      else if (idx == REG_ATLAS_HEIGHT) height_reg = val;
    endfunction

    // Highest top over the box span starting at segment s.
    function bit span_top(int s, int w, int aw, output int top);
      int rem;
      rem = w;
      top = seg_top[s];
      if (int'(seg_left[s]) + w > aw) return 0;
      for (int i = s; i < seg_count; i++) begin
        if (seg_top[i] > top) top = seg_top[i];
        if (seg_span[i] >= rem) return 1;
        rem -= seg_span[i];
      end
      return 0;
    endfunction

    function void note_beat(logic cmd, logic [DIM_W-1:0] bw, logic [DIM_W-1:0] bh);
      place_t p;
      int aw, ah, w, h, best_y, best_x, best_i, y, used, last, old_top, leftover;
      int ins, newc, n;
      bit found;
      logic [POS_W-1:0] nl[SEG_N];
      logic [DIM_W-1:0] nt[SEG_N];
      logic [DIM_W-1:0] ns[SEG_N];
      p.x = '0;
      p.y = '0;
      p.st = STAT_OK;
      aw = clip(width_reg);
      ah = clip(height_reg);
      w = bw;
      h = bh;
      found = 0;
      best_y = ah;
      best_x = 0;
      best_i = 0;
      if (cmd == CMD_CLEAR) begin
        flatten();
      end else if (w == 0 || h == 0 || w > aw || h > ah) begin
        p.st = STAT_NOFIT;
      end else begin
        for (int i = 0; i < seg_count; i++) begin
          if (!span_top(i, w, aw, y)) continue;
          if (y + h > ah) continue;
          if (y < best_y) begin
            best_y = y;
            best_x = seg_left[i];
            best_i = i;
            found = 1;
          end
        end
        if (!found) begin
          p.st = STAT_NOFIT;
        end else begin
          used = 0;
          last = best_i;
          old_top = 0;
          while (last < seg_count && used < w) begin
            used += seg_span[last];
            old_top = seg_top[last];
            last++;
          end
          leftover = used - w;
          ins = (leftover > 0) ? 2 : 1;
          newc = seg_count - (last - best_i) + ins;
          if (newc > SEG_N) begin
            p.st = STAT_FULL;
          end else begin
            // Rebuild the table: head, raised segment, tail piece, rest.
            n = 0;
            for (int i = 0; i < best_i; i++) begin
              nl[n] = seg_left[i]; nt[n] = seg_top[i]; ns[n] = seg_span[i]; n++;
            end
            nl[n] = POS_W'(best_x); nt[n] = DIM_W'(best_y + h); ns[n] = DIM_W'(w); n++;
            if (leftover > 0) begin
              nl[n] = POS_W'(best_x + w); nt[n] = DIM_W'(old_top);
              ns[n] = DIM_W'(leftover); n++;
            end
            for (int i = last; i < seg_count; i++) begin
              nl[n] = seg_left[i]; nt[n] = seg_top[i]; ns[n] = seg_span[i]; n++;
            end
            for (int i = 0; i < n; i++) begin
              seg_left[i] = nl[i]; seg_top[i] = nt[i]; seg_span[i] = ns[i];
            end
            seg_count = newc;
            p.x = POS_W'(best_x);
            p.y = POS_W'(best_y);
          end
        end
      end
      placement_q.insert(placement_q.size(), p);
    endfunction

    function void check_result(logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [1:0] st);
      place_t p;
      if (placement_q.size() == 0) begin
        $display("%0t: unexpected result beat x=%0d y=%0d status=%0d", $time, x, y, st);
        errors++;
        return;
      end
      p = placement_q.pop_front();
      if (st !== p.st) begin
        $display("%0t: status expected %0d actual %0d", $time, p.st, st);
        errors++;
      end
      if (x !== p.x) begin
        $display("%0t: pos_x expected %0d actual %0d", $time, p.x, x);
        errors++;
      end
      if (y !== p.y) begin
        $display("%0t: pos_y expected %0d actual %0d", $time, p.y, y);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [1:0]       cfg_index_i;
  logic [DIM_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             command_i;
  logic [DIM_W-1:0] box_width_i;
  logic [DIM_W-1:0] box_height_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [POS_W-1:0] pos_x_o;
  logic [POS_W-1:0] pos_y_o;
  logic [1:0]       status_o;

  skyline_scoreboard sb;
  int                idle_cycles;
  int                burst_left;
  int                stall_mode;

  skyline_rect_allocator_top dut (.*);

  // 50 MHz clock.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Check every result beat that the block hands over.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(pos_x_o, pos_y_o, status_o);
  end

  // The receiver changes its stall habit at random times.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 9) < 3);
        default: out_stall_i <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // Ends the run when no beat moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Drives one input beat from a falling edge and holds it until taken.
  // Between bursts the valid drops for a random gap.
  task automatic send_beat(logic cmd, logic [DIM_W-1:0] bw, logic [DIM_W-1:0] bh);
    in_valid_i = 1'b1;
    command_i = cmd;
    box_width_i = bw;
    box_height_i = bh;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.note_beat(cmd, bw, bh);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
    end
  endtask

  // Lets the block drain before a register write.
  task automatic settle();
    in_valid_i = 1'b0;
    while (sb.placement_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DIM_W-1:0] val);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [DIM_W-1:0] pick_dim(int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return DIM_W'($urandom_range(1, (lim / 8 > 1) ? lim / 8 : 1));
    if (r < 75) return DIM_W'($urandom_range(1, lim));
    if (r < 88) return DIM_W'($urandom_range(1, 4));
    return DIM_W'($urandom_range(0, 8191));
  endfunction

  // Packs unit boxes until the segment table overflows.
  task automatic fill_table();
    send_beat(CMD_CLEAR, '0, '0);
    for (int i = 0; i < SEG_N + 2; i++) send_beat(CMD_PACK, 13'd1, 13'd1);
  endtask

  initial begin
    int wset[8];
    int hset[8];
    int aw, ah;
    wset = '{1024, 1, 4096, 8191, 16, 300, 4096, 77};
    hset = '{1024, 1, 4096, 8191, 4096, 50, 1, 900};
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_ATLAS_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    command_i = CMD_PACK;
    box_width_i = '0;
    box_height_i = '0;
    idle_cycles = 0;
    burst_left = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part at the reset configuration.
    send_beat(CMD_PACK, 13'd1024, 13'd1024);
    send_beat(CMD_PACK, 13'd1, 13'd1);
    send_beat(CMD_CLEAR, 13'h1fff, 13'h1fff);
    send_beat(CMD_PACK, 13'd0, 13'd5);
    send_beat(CMD_PACK, 13'd5, 13'd0);
    send_beat(CMD_PACK, 13'd4096, 13'd1);
    send_beat(CMD_PACK, 13'h1fff, 13'h1fff);
    send_beat(CMD_PACK, 13'd1023, 13'd5);
    send_beat(CMD_PACK, 13'd2, 13'd1);
    send_beat(CMD_PACK, 13'd1, 13'd1024);
    send_beat(CMD_PACK, 13'd512, 13'd100);
    send_beat(CMD_PACK, 13'd1, 13'd1019);
    send_beat(CMD_PACK, 13'd1, 13'd1);
    settle();

    // Narrowing the atlas without a clear keeps the wide table.
    write_reg(REG_ATLAS_WIDTH, 13'd16);
    send_beat(CMD_PACK, 13'd16, 13'd1);
    send_beat(CMD_PACK, 13'd17, 13'd1);
    send_beat(CMD_CLEAR, '0, '0);
    send_beat(CMD_PACK, 13'd16, 13'd3);
    settle();

    // Widening without a clear leaves the table short of the box span.
    write_reg(REG_ATLAS_WIDTH, 13'd4096);
    send_beat(CMD_PACK, 13'd100, 13'd1);
    send_beat(CMD_PACK, 13'd8, 13'd1);
    send_beat(CMD_CLEAR, '0, '0);
    send_beat(CMD_PACK, 13'd4096, 13'd1);
    settle();

    // Random phases over several atlas settings.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_ATLAS_WIDTH, DIM_W'(wset[ph]));
      write_reg(REG_ATLAS_HEIGHT, DIM_W'(hset[ph]));
      aw = (wset[ph] > 4096) ? 4096 : wset[ph];
      ah = (hset[ph] > 4096) ? 4096 : hset[ph];
      if (ph != 5) send_beat(CMD_CLEAR, DIM_W'($urandom), DIM_W'($urandom));
      if (ph == 2 || ph == 6) fill_table();
      for (int i = 0; i < 124; i++) begin
        if ($urandom_range(0, 14) == 0)
          send_beat(CMD_CLEAR, DIM_W'($urandom), DIM_W'($urandom));
        else
          send_beat(CMD_PACK, pick_dim(aw), pick_dim(ah));
      end
      settle();
    end

    // Final drain.
    repeat (50) @(negedge clk_i);
    if (sb.errors == 0 && sb.placement_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (sb.placement_q.size() != 0)
        $display("%0t: %0d results never arrived", $time, sb.placement_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
